[hw/rtl/relay_header_node_list_parser_macros.svh]
// Assertion macros for the relay header parser.
`ifndef RELAY_HEADER_NODE_LIST_PARSER_MACROS_SVH
`define RELAY_HEADER_NODE_LIST_PARSER_MACROS_SVH

// Antecedent implies consequent in the same cycle, checked out of reset.
`define RHNLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle, checked out of reset.
`define RHNLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rhnlp_pkg.sv]
package rhnlp_pkg;

  localparam int unsigned TimestampLen = 8;
  localparam logic [7:0] FrameType = 8'h02;

  typedef enum logic [3:0] {
    PhType    = 4'd0,
    PhSender  = 4'd1,
    PhGcount  = 4'd2,
    PhGood    = 4'd3,
    PhBcount  = 4'd4,
    PhBad     = 4'd5,
    PhTs      = 4'd6,
    PhPayload = 4'd7,
    PhDiscard = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KindGood = 2'd0,
    KindBad  = 2'd1,
    KindData = 2'd2,
    KindEnd  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic        frame_end;
    logic        frame_ok;
  } result_t;

endpackage

[hw/rtl/rhnlp_core.sv]
module rhnlp_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output logic               have_o,
  output rhnlp_pkg::result_t result_o
);

  localparam logic [4:0] TsLenW = 5'(rhnlp_pkg::TimestampLen);
  localparam rhnlp_pkg::phase_e TsEntry =
    (rhnlp_pkg::TimestampLen == 0) ? rhnlp_pkg::PhPayload : rhnlp_pkg::PhTs;

  rhnlp_pkg::phase_e phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic [3:0]  bif_q, bif_d;
  logic [7:0]  hold_q, hold_d;
  logic        mismatch_q, mismatch_d;

  logic        have;
  rhnlp_pkg::kind_e kind;
  logic [15:0] word;
  logic [15:0] left_dec;

  assign word     = {hold_q, byte_i};
  assign left_dec = left_q - 16'd1;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    bif_d      = bif_q;
    hold_d     = hold_q;
    mismatch_d = mismatch_q;
    have       = 1'b0;
    kind       = rhnlp_pkg::KindEnd;

    case (phase_q)
      rhnlp_pkg::PhType: begin
        if (byte_i == rhnlp_pkg::FrameType) begin
          phase_d = rhnlp_pkg::PhSender;
          bif_d   = 4'd0;
        end else begin
          mismatch_d = 1'b1;
          phase_d    = rhnlp_pkg::PhDiscard;
        end
      end
      rhnlp_pkg::PhSender, rhnlp_pkg::PhGcount, rhnlp_pkg::PhGood,
      rhnlp_pkg::PhBcount, rhnlp_pkg::PhBad: begin
        if (bif_q == 4'd0) begin
          hold_d = byte_i;
          bif_d  = 4'd1;
        end else begin
          bif_d = 4'd0;
          case (phase_q)
            rhnlp_pkg::PhSender: begin
              have    = 1'b1;
              kind    = rhnlp_pkg::KindGood;
              phase_d = rhnlp_pkg::PhGcount;
            end
            rhnlp_pkg::PhGcount: begin
              left_d  = word;
              phase_d = (word == 16'd0) ? rhnlp_pkg::PhBcount : rhnlp_pkg::PhGood;
            end
            rhnlp_pkg::PhGood: begin
              have   = 1'b1;
              kind   = rhnlp_pkg::KindGood;
              left_d = left_dec;
              if (left_dec == 16'd0) begin
                phase_d = rhnlp_pkg::PhBcount;
              end
            end
            rhnlp_pkg::PhBcount: begin
              left_d = word;
              if (word == 16'd0) begin
                phase_d = TsEntry;
              end else begin
                phase_d = rhnlp_pkg::PhBad;
              end
            end
            default: begin
              have   = 1'b1;
              kind   = rhnlp_pkg::KindBad;
              left_d = left_dec;
              if (left_dec == 16'd0) begin
                phase_d = TsEntry;
              end
            end
          endcase
        end
      end
      rhnlp_pkg::PhTs: begin
        if ({1'b0, bif_q} + 5'd1 >= TsLenW) begin
          bif_d   = 4'd0;
          phase_d = rhnlp_pkg::PhPayload;
        end else begin
          bif_d = bif_q + 4'd1;
        end
      end
      rhnlp_pkg::PhPayload: begin
        have = 1'b1;
        kind = rhnlp_pkg::KindData;
      end
      default: begin
        phase_d = rhnlp_pkg::PhDiscard;
      end
    endcase
  end

  always_comb begin
    have_o             = have || last_i;
    result_o.kind      = kind;
    result_o.frame_end = last_i;
    result_o.frame_ok  = last_i && !mismatch_d && (phase_d == rhnlp_pkg::PhPayload);
    if (!have) begin
      result_o.value = 16'd0;
    end else if (kind == rhnlp_pkg::KindData) begin
      result_o.value = {8'd0, byte_i};
    end else begin
      result_o.value = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rhnlp_pkg::PhType;
      left_q     <= 16'd0;
      bif_q      <= 4'd0;
      hold_q     <= 8'd0;
      mismatch_q <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q    <= rhnlp_pkg::PhType;
        left_q     <= 16'd0;
        bif_q      <= 4'd0;
        hold_q     <= 8'd0;
        mismatch_q <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        left_q     <= left_d;
        bif_q      <= bif_d;
        hold_q     <= hold_d;
        mismatch_q <= mismatch_d;
      end
    end
  end

endmodule

[hw/rtl/relay_header_node_list_parser.sv]
// Relay frame header parser. One frame byte is taken per beat on the slave side, with tlast
// on the final byte. A beat is taken every clock cycle while the slave side is ready, which
// holds as long as the output register is empty or is being drained in the same cycle. Each
// node id is reported as a good or bad entry once its second byte arrives, payload bytes
// pass straight through, and the final byte always yields a result carrying the frame
// status. Results appear in a single output register in the cycle after their input beat.
`include "relay_header_node_list_parser_macros.svh"

module relay_header_node_list_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] value, [16] frame_ok, [23:17] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o
);

  logic               accept;
  logic               have;
  rhnlp_pkg::result_t result;
  rhnlp_pkg::result_t out_q;
  logic               out_valid_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  rhnlp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .have_o   (have),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= accept && have;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && have) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_q.frame_ok, out_q.value};
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tlast_o  = out_q.frame_end;

  `RHNLP_ASSERT_IMPL(a_ok_needs_end, m_axis_tvalid_o && m_axis_tdata_o[16], m_axis_tlast_o,
    "frame status set on a beat that does not end the frame")
  `RHNLP_ASSERT_IMPL(a_end_marker_last,
    m_axis_tvalid_o && (m_axis_tuser_o == rhnlp_pkg::KindEnd),
    m_axis_tlast_o && (m_axis_tdata_o[15:0] == 16'd0),
    "end marker without tlast or with nonzero value")
  `RHNLP_ASSERT_NEXT(a_last_gives_result, accept && s_axis_tlast_i,
    m_axis_tvalid_o && m_axis_tlast_o,
    "final input beat produced no closing result")

endmodule
